>>> rtl/brps_pkg.sv
// Shared constants, types and control structures of the block range page splitter.
package brps_pkg;

  localparam int START_W          = 64;
  localparam int COUNT_W          = 9;
  localparam int PAGE_W           = 61;
  localparam int OFF_W            = 12;
  localparam int LEN_W            = 13;
  localparam int TOTAL_W          = 18;
  localparam int SEC_OFF_W        = 3;
  localparam int SECTOR_SHIFT     = 9;
  localparam int LEN_SEC_W        = 4;
  localparam int SECTORS_PER_PAGE = 8;
  localparam int MAX_SEGMENTS_DEF = 64;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } brps_state_t;

  typedef struct packed {
    logic load;
    logic step;
  } brps_cmd_t;

  typedef struct packed {
    logic req_ok;
    logic seg_last;
    logic out_free;
  } brps_status_t;

endpackage

>>> rtl/block_range_page_splitter.sv
// Top level of the block range page splitter: controller plus datapath.
//
//  Channel  Direction  Handshake              Payload
//  in_      input      in_valid / in_ready    start_sector[63:0], sector_count[8:0]
//  out_     output     out_valid / out_ready  page_number[60:0], offset_bytes[11:0],
//                                             length_bytes[12:0], total_bytes[17:0],
//                                             last_segment
//
// A request is accepted while the controller is idle, and its page segments then
// issue one per cycle while the output is free; the single output register issues
// at most one segment per cycle.
// Requests with a zero sector count or more sectors than fit in MAX_SEGMENTS pages
// from the last sector of a page are taken and produce no segments.
// Reset is synchronous and active low; it returns the controller to idle and empties
// the output register.
// A stalled output holds the current segment and pauses segment issue; a new request
// is taken as soon as the last segment of the previous one sits in the output register.
module block_range_page_splitter
  import brps_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [START_W-1:0] in_start_sector,
  input  logic [COUNT_W-1:0] in_sector_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PAGE_W-1:0]  out_page_number,
  output logic [OFF_W-1:0]   out_offset_bytes,
  output logic [LEN_W-1:0]   out_length_bytes,
  output logic [TOTAL_W-1:0] out_total_bytes,
  output logic               out_last_segment
);

  // Commands from the controller and status back from the datapath.
  brps_cmd_t    cmd;
  brps_status_t status;

  // The controller decides when a request transfer is taken and when the next
  // segment may move into the output register.
  brps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the request, walks the pages one per segment and forms
  // each segment's offset and length from the first and last sector positions.
  brps_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_start_sector  (in_start_sector),
    .in_sector_count  (in_sector_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_page_number  (out_page_number),
    .out_offset_bytes (out_offset_bytes),
    .out_length_bytes (out_length_bytes),
    .out_total_bytes  (out_total_bytes),
    .out_last_segment (out_last_segment)
  );

endmodule

>>> rtl/brps_dp.sv
// Datapath of the page splitter: request registers, segment counters and output register.
module brps_dp
  import brps_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  brps_cmd_t           cmd,
  output brps_status_t        status,
  input  logic [START_W-1:0]  in_start_sector,
  input  logic [COUNT_W-1:0]  in_sector_count,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [PAGE_W-1:0]   out_page_number,
  output logic [OFF_W-1:0]    out_offset_bytes,
  output logic [LEN_W-1:0]    out_length_bytes,
  output logic [TOTAL_W-1:0]  out_total_bytes,
  output logic                out_last_segment
);

  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int LIMIT = MAX_SEGMENTS * SECTORS_PER_PAGE - 7;
  localparam int SUM_W = COUNT_W + 1;

  logic [PAGE_W-1:0]    page_r, page_nxt;
  logic [SEC_OFF_W-1:0] off_sec_r, off_sec_nxt;
  logic [SEC_OFF_W-1:0] end_low_r, end_low_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]     left_r, left_nxt;
  logic                 first_r, first_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [PAGE_W-1:0]    out_page_r;
  logic [OFF_W-1:0]     out_off_r;
  logic [LEN_W-1:0]     out_len_r;
  logic [TOTAL_W-1:0]   out_total_r;
  logic                 out_last_r;

  logic [SUM_W-1:0]     end_sum;
  logic [SUM_W-1:0]     page_sum;
  logic [SUM_W-4:0]     pages;
  logic                 seg_last;
  logic [LEN_SEC_W-1:0] len_sec;

  // Sector at which the request ends, counted from its first page.
  assign end_sum  = SUM_W'(in_sector_count) + SUM_W'(in_start_sector[SEC_OFF_W-1:0]);
  assign page_sum = end_sum + SUM_W'(SECTORS_PER_PAGE - 1);
  assign pages    = page_sum[SUM_W-1:SEC_OFF_W];

  assign seg_last = (left_r == CNT_W'(1));

  always_comb begin
    if (first_r && seg_last) begin
      len_sec = count_r[LEN_SEC_W-1:0];
    end else if (first_r) begin
      len_sec = LEN_SEC_W'(SECTORS_PER_PAGE) - LEN_SEC_W'(off_sec_r);
    end else if (seg_last && (end_low_r != '0)) begin
      len_sec = LEN_SEC_W'(end_low_r);
    end else begin
      len_sec = LEN_SEC_W'(SECTORS_PER_PAGE);
    end
  end

  always_comb begin
    page_nxt    = page_r;
    off_sec_nxt = off_sec_r;
    end_low_nxt = end_low_r;
    count_nxt   = count_r;
    left_nxt    = left_r;
    first_nxt   = first_r;
    if (cmd.load) begin
      page_nxt    = in_start_sector[START_W-1:SEC_OFF_W];
      off_sec_nxt = in_start_sector[SEC_OFF_W-1:0];
      end_low_nxt = end_sum[SEC_OFF_W-1:0];
      count_nxt   = in_sector_count;
      left_nxt    = pages[CNT_W-1:0];
      first_nxt   = 1'b1;
    end else if (cmd.step) begin
      page_nxt  = page_r + PAGE_W'(1);
      left_nxt  = left_r - CNT_W'(1);
      first_nxt = 1'b0;
    end
  end

  always_comb begin
    if (cmd.step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= '0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      left_r      <= left_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r    <= page_nxt;
    off_sec_r <= off_sec_nxt;
    end_low_r <= end_low_nxt;
    count_r   <= count_nxt;
    if (cmd.step) begin
      out_page_r  <= page_r;
      out_off_r   <= first_r ? {off_sec_r, {SECTOR_SHIFT{1'b0}}} : '0;
      out_len_r   <= {len_sec, {SECTOR_SHIFT{1'b0}}};
      out_total_r <= {count_r, {SECTOR_SHIFT{1'b0}}};
      out_last_r  <= seg_last;
    end
  end

  assign status.req_ok   = (in_sector_count != '0) && (in_sector_count <= COUNT_W'(LIMIT));
  assign status.seg_last = seg_last;
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_page_number  = out_page_r;
  assign out_offset_bytes = out_off_r;
  assign out_length_bytes = out_len_r;
  assign out_total_bytes  = out_total_r;
  assign out_last_segment = out_last_r;

`ifndef SYNTHESIS
  a_step_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (left_r != '0))
    else $error("segment issued with no segments left");

  a_step_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (!out_valid_r || out_ready))
    else $error("segment overwrote an untaken result");

  a_no_load_during_step: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.step))
    else $error("request loaded while segments were being issued");

  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && seg_last) |=> (left_r == '0) && out_last_segment)
    else $error("final segment did not close the request");
`endif

endmodule

>>> rtl/brps_ctrl.sv
// Controller state machine of the page splitter.
module brps_ctrl
  import brps_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  brps_status_t status,
  output brps_cmd_t    cmd
);

  brps_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && status.req_ok) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free && status.seg_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid && status.req_ok;
      end
      ST_EMIT: begin
        cmd.step = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_emit_leaves_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && !(status.out_free && status.seg_last)) |=> (state_r == ST_EMIT))
    else $error("request abandoned before its final segment");

  a_load_starts_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == ST_EMIT) && !in_ready)
    else $error("accepted request did not start segment issue");

  a_no_step_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !cmd.step)
    else $error("segment issued while idle");
`endif

endmodule

>>> verif/block_range_page_splitter_tb.sv
// Self-checking testbench for the block range page splitter.
`timescale 1ns / 1ps

module block_range_page_splitter_tb;
  import brps_pkg::*;

  // Longest count that still fits in MAX_SEGMENTS pages when the request starts
  // at the last sector of a page.
  localparam int unsigned SECTOR_LIMIT = MAX_SEGMENTS_DEF * SECTORS_PER_PAGE - 7;
  localparam int unsigned PAGE_BYTES   = 4096;
  localparam int unsigned SECTOR_BYTES = 512;
  localparam int          RANDOM_ITEMS = 450;
  localparam int          HOLD_ITEMS   = 24;
  localparam int          RX_HOLD_CYCLES = 400;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          TIMEOUT_NS   = 5_000_000;

  // One page segment, as it leaves the block.
  typedef struct packed {
    logic [PAGE_W-1:0]  page_number;
    logic [OFF_W-1:0]   offset_bytes;
    logic [LEN_W-1:0]   length_bytes;
    logic [TOTAL_W-1:0] total_bytes;
    logic               last_segment;
  } segment_t;

  // Works out the page segments of each accepted request and checks the
  // segments that the block issues against them, oldest first.
  class segment_scoreboard;
    segment_t    pending_segments[$];
    int unsigned requests_split;
    int unsigned requests_refused;
    int unsigned segments_checked;
    int unsigned widest_request;
    int unsigned failures;

    function void note_request(logic [START_W-1:0] start, logic [COUNT_W-1:0] count);
      segment_t          seg;
      logic [PAGE_W-1:0] base;
      int unsigned       sec_off;
      int unsigned       first_off;
      int unsigned       total;
      int unsigned       pages;
      int unsigned       len;
      int unsigned       idx;
      if (count == 0 || count > SECTOR_LIMIT) begin
        requests_refused++;
        return;
      end
      sec_off   = int'(start[SEC_OFF_W-1:0]);
      base      = start[START_W-1:SEC_OFF_W];
      first_off = sec_off * SECTOR_BYTES;
      total     = int'(count) * SECTOR_BYTES;
      pages     = (sec_off + int'(count) + SECTORS_PER_PAGE - 1) / SECTORS_PER_PAGE;
      for (idx = 0; idx < pages; idx++) begin
        if (idx == 0) begin
          len = PAGE_BYTES - first_off;
          if (len > total) len = total;
        end else begin
          len = PAGE_BYTES;
          if (PAGE_BYTES * (idx + 1) - first_off > total)
            len = (total + first_off) % PAGE_BYTES;
        end
        seg.page_number  = base + PAGE_W'(idx);
        seg.offset_bytes = (idx == 0) ? OFF_W'(first_off) : '0;
        seg.length_bytes = LEN_W'(len);
        seg.total_bytes  = TOTAL_W'(total);
        seg.last_segment = (idx + 1 == pages);
        pending_segments.push_back(seg);
      end
      requests_split++;
      if (pages > widest_request) widest_request = pages;
    endfunction

    function void check_segment(segment_t got);
      segment_t exp;
      if (pending_segments.size() == 0) begin
        $error("segment with page_number %0d issued with none outstanding",
               got.page_number);
        failures++;
        return;
      end
      exp = pending_segments.pop_front();
      segments_checked++;
      if (got.page_number !== exp.page_number) begin
        $error("page_number: expected %0d, got %0d", exp.page_number, got.page_number);
        failures++;
      end
      if (got.offset_bytes !== exp.offset_bytes) begin
        $error("offset_bytes: expected %0d, got %0d", exp.offset_bytes, got.offset_bytes);
        failures++;
      end
      if (got.length_bytes !== exp.length_bytes) begin
        $error("length_bytes: expected %0d, got %0d", exp.length_bytes, got.length_bytes);
        failures++;
      end
      if (got.total_bytes !== exp.total_bytes) begin
        $error("total_bytes: expected %0d, got %0d", exp.total_bytes, got.total_bytes);
        failures++;
      end
      if (got.last_segment !== exp.last_segment) begin
        $error("last_segment: expected %0d, got %0d", exp.last_segment, got.last_segment);
        failures++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_segments.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [START_W-1:0] in_start_sector = '0;
  logic [COUNT_W-1:0] in_sector_count = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [PAGE_W-1:0]  out_page_number;
  logic [OFF_W-1:0]   out_offset_bytes;
  logic [LEN_W-1:0]   out_length_bytes;
  logic [TOTAL_W-1:0] out_total_bytes;
  logic               out_last_segment;

  // Idle percentages of the two sides; the main sequence changes them per phase.
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  // Set by the main sequence to ask the receiver for one long hold-off.
  bit          rx_hold_req = 1'b0;

  segment_scoreboard sb = new();

  block_range_page_splitter i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_start_sector  (in_start_sector),
    .in_sector_count  (in_sector_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_page_number  (out_page_number),
    .out_offset_bytes (out_offset_bytes),
    .out_length_bytes (out_length_bytes),
    .out_total_bytes  (out_total_bytes),
    .out_last_segment (out_last_segment)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs or loses a segment.
  initial begin
    #(TIMEOUT_NS);
    $display("block_range_page_splitter_tb NOT OK");
    $finish;
  end

  // Receiver. Every edge it decides afresh whether to take a segment, unless a
  // long hold-off has been asked for, in which case it counts the stretch out
  // itself while the sender keeps offering requests and the block backs up.
  always begin
    @(posedge clk);
    if (rx_hold_req) begin
      out_ready <= 1'b0;
      repeat (RX_HOLD_CYCLES) @(posedge clk);
      rx_hold_req = 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Output monitor. Signals are read in the active region right after the edge,
  // so they hold the values that the block saw at that edge; a transfer took
  // place if valid and ready were both high.
  always @(posedge clk) begin
    segment_t got;
    if (rst_n && out_valid && out_ready) begin
      got.page_number  = out_page_number;
      got.offset_bytes = out_offset_bytes;
      got.length_bytes = out_length_bytes;
      got.total_bytes  = out_total_bytes;
      got.last_segment = out_last_segment;
      sb.check_segment(got);
    end
  end

  // Offers one request, with a random idle gap first, and returns at the edge
  // at which it was transferred. The request is handed to the scoreboard
  // there, before its first segment can possibly appear.
  task automatic send_request(input logic [START_W-1:0] start,
                              input logic [COUNT_W-1:0] count);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_start_sector <= start;
    in_sector_count <= count;
    do @(posedge clk); while (!in_ready);
    sb.note_request(start, count);
  endtask

  // The sender pauses here until every expected segment has come back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // Start sectors: mostly the whole 64-bit space, some low addresses, and some
  // just under the top so that page numbers wrap round to zero.
  function automatic logic [START_W-1:0] random_start();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return {START_W{1'b1}} - START_W'($urandom_range(600));
    if (pick == 1) return START_W'($urandom_range(4095));
    return {$urandom, $urandom};
  endfunction

  // Counts: mostly a few pages, fewer long requests, and a small share of
  // refused ones (zero or beyond the page limit).
  function automatic logic [COUNT_W-1:0] random_count();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 2) return '0;
    if (pick < 6) return COUNT_W'($urandom_range(511, SECTOR_LIMIT + 1));
    if (pick < 70) return COUNT_W'($urandom_range(24, 1));
    if (pick < 88) return COUNT_W'($urandom_range(200, 25));
    return COUNT_W'($urandom_range(SECTOR_LIMIT, 201));
  endfunction

  // Sends the given number of random requests, refused ones included.
  task automatic send_random(input int unsigned n_items);
    repeat (n_items) send_request(random_start(), random_count());
  endtask

  initial begin
    int unsigned phase_items;
    phase_items = (RANDOM_ITEMS - HOLD_ITEMS) / 3;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests: smallest and largest counts, first and last sector of
    // a page, transfers ending exactly on a page boundary, the widest request
    // of 64 pages, refused counts, and page numbers wrapping at the top of the
    // address space.
    send_request('0, 9'd1);
    send_request('0, 9'd8);
    send_request(64'd3, 9'd5);
    send_request('0, 9'd16);
    send_request(64'd4, 9'd12);
    send_request(64'd7, 9'd1);
    send_request(64'd7, 9'd2);
    send_request(64'd1, 9'd15);
    send_request(64'd2, 9'd6);
    send_request('0, COUNT_W'(SECTOR_LIMIT));
    send_request(64'd7, COUNT_W'(SECTOR_LIMIT));
    send_request('0, '0);
    send_request('0, COUNT_W'(SECTOR_LIMIT + 1));
    send_request({START_W{1'b1}}, {COUNT_W{1'b1}});
    send_request({START_W{1'b1}}, 9'd1);
    send_request({START_W{1'b1}}, 9'd9);
    send_request(64'hFFFF_FFFF_FFFF_FFF8, COUNT_W'(SECTOR_LIMIT));
    send_request(64'h5555_5555_5555_5555, 9'd256);
    send_request(64'hAAAA_AAAA_AAAA_AAAA, 9'd255);
    send_request(64'h8000_0000_0000_0000, 9'd100);
    wait_for_drain();

    // Sender idles now and then, receiver stalls most of the time.
    tx_idle_pct = 24;
    rx_idle_pct = 62;
    send_random(phase_items);
    wait_for_drain();

    // The other way round.
    tx_idle_pct = 62;
    rx_idle_pct = 24;
    send_random(phase_items);
    wait_for_drain();

    // No idling; first a long hold-off at the receiver with the sender still
    // pushing, so that the output register fills and the input stalls.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_req = 1'b1;
    send_random(HOLD_ITEMS);
    send_random(RANDOM_ITEMS - HOLD_ITEMS - 2 * phase_items);
    wait_for_drain();

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Split %0d requests into %0d checked segments (widest %0d pages);",
             sb.requests_split, sb.segments_checked, sb.widest_request);
    $display("%0d requests with a zero or oversized count were refused.",
             sb.requests_refused);
    if (sb.failures == 0) begin
      $display("block_range_page_splitter_tb OK");
    end else begin
      $display("block_range_page_splitter_tb NOT OK");
    end
    $finish;
  end

endmodule
